// ----- design/cts_pkg.sv -----
// shared types, constants and the month-start table for calendar_to_epoch_seconds
package cts_pkg;

    // field widths
    localparam int YEAR_W   = 10;
    localparam int MONTH_W  = 4;
    localparam int MDAY_W   = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int EPOCH_W  = 35;

    // calendar year of a given offset, and working widths
    localparam int YEAR_BASE   = 1900;
    localparam int CAL_YEAR_W  = 12;
    localparam int CENTURY_W   = 5;
    localparam int YEAR_DAYS_W = 19;
    localparam int MSTART_W    = 9;

    // year offset of the epoch; offsets above it add whole years (1971 counts 1970)
    localparam int EPOCH_YEAR_OFF = 70;
    // leap years up to and including 1969 under the gregorian rule
    localparam int LEAPS_BEFORE_EPOCH = 477;
    // floor(n/100) = (n * RECIP_100) >> RECIP_SHIFT for n below 43000
    localparam int RECIP_100   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int DIV_PROD_W  = CAL_YEAR_W + RECIP_W;

    // datapath operations, one per controller step
    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_DIV_PREV = 3'd1,
        OP_DIV_CUR  = 3'd2,
        OP_YEAR     = 3'd3,
        OP_MONTH    = 3'd4,
        OP_HOUR     = 3'd5,
        OP_MIN      = 3'd6,
        OP_SEC      = 3'd7
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic out_free;
    } sts_t;

    // days in the year before the first day of a month, month clamped to 12
    function automatic logic [MSTART_W-1:0] month_start(input logic leap,
                                                        input logic [MONTH_W-1:0] mon);
        logic [MSTART_W-1:0] base;
        logic                add_leap;
        begin
            add_leap = 1'b1;
            case (mon)
                4'd0:    begin base = 9'd0;   add_leap = 1'b0; end
                4'd1:    begin base = 9'd31;  add_leap = 1'b0; end
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd365;
            endcase
            month_start = base + {{(MSTART_W-1){1'b0}}, leap & add_leap};
        end
    endfunction

endpackage

// ----- design/cts_if.sv -----
// request and response channel interfaces
interface cts_req_if
    import cts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_from_1900;
    logic [MONTH_W-1:0]  month;
    logic [MDAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;

    modport source (output valid, year_from_1900, month, day_of_month, hour, minute, second,
                    input ready);
    modport sink (input valid, year_from_1900, month, day_of_month, hour, minute, second,
                  output ready);
endinterface

interface cts_rsp_if
    import cts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, epoch_seconds, input ready);
    modport sink (input valid, epoch_seconds, output ready);
endinterface

// ----- design/cts_ctrl.sv -----
// step sequencer for the epoch conversion
module cts_ctrl
    import cts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIVP = 8'b0000_0010,
        ST_DIVC = 8'b0000_0100,
        ST_YEAR = 8'b0000_1000,
        ST_MON  = 8'b0001_0000,
        ST_HOUR = 8'b0010_0000,
        ST_MIN  = 8'b0100_0000,
        ST_SEC  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (sts.accept) state_next = ST_DIVP;
            ST_DIVP: state_next = ST_DIVC;
            ST_DIVC: state_next = ST_YEAR;
            ST_YEAR: state_next = ST_MON;
            ST_MON:  state_next = ST_HOUR;
            ST_HOUR: state_next = ST_MIN;
            ST_MIN:  state_next = ST_SEC;
            ST_SEC:  if (sts.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // operation for the current step
    always_comb
    begin
        case (state_reg)
            ST_IDLE: cmd.op = OP_LOAD;
            ST_DIVP: cmd.op = OP_DIV_PREV;
            ST_DIVC: cmd.op = OP_DIV_CUR;
            ST_YEAR: cmd.op = OP_YEAR;
            ST_MON:  cmd.op = OP_MONTH;
            ST_HOUR: cmd.op = OP_HOUR;
            ST_MIN:  cmd.op = OP_MIN;
            ST_SEC:  cmd.op = OP_SEC;
            default: cmd.op = OP_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/cts_dp.sv -----
// datapath: century quotients, day count, multiply-add to seconds, output register
module cts_dp
    import cts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                accept,
    input  logic [YEAR_W-1:0]   year_from_1900,
    input  logic [MONTH_W-1:0]  month,
    input  logic [MDAY_W-1:0]   day_of_month,
    input  logic [HOUR_W-1:0]   hour,
    input  logic [MINUTE_W-1:0] minute,
    input  logic [SECOND_W-1:0] second,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [EPOCH_W-1:0]  epoch_seconds,
    output logic                out_free
);

    logic [YEAR_W-1:0]      year_reg;
    logic [MONTH_W-1:0]     month_reg;
    logic [MDAY_W-1:0]      mday_reg;
    logic [HOUR_W-1:0]      hour_reg;
    logic [MINUTE_W-1:0]    minute_reg;
    logic [SECOND_W-1:0]    second_reg;
    logic [CENTURY_W-1:0]   q_prev_reg;
    logic [CENTURY_W-1:0]   q_cur_reg;
    logic                   leap_reg;
    logic                   leap_next;
    logic [EPOCH_W-1:0]     acc_reg;
    logic [EPOCH_W-1:0]     acc_next;
    logic                   out_valid_reg;
    logic [EPOCH_W-1:0]     epoch_reg;

    logic [CAL_YEAR_W-1:0]  y_cur;
    logic [CAL_YEAR_W-1:0]  y_prev;
    logic [CAL_YEAR_W-1:0]  div_n;
    logic [DIV_PROD_W-1:0]  div_prod;
    logic [CENTURY_W-1:0]   div_q;
    logic [CAL_YEAR_W-1:0]  leaps;
    logic [CAL_YEAR_W-1:0]  century_start;
    logic [YEAR_W-1:0]      whole_years;
    logic [YEAR_DAYS_W-1:0] year_days;
    logic                   has_years;

    function automatic logic [CAL_YEAR_W-1:0] year_from_1900_ext(input logic [YEAR_W-1:0] y);
        year_from_1900_ext = {{(CAL_YEAR_W-YEAR_W){1'b0}}, y};
    endfunction

    // calendar year and the last whole year before it
    assign y_cur  = CAL_YEAR_W'(year_from_1900_ext(year_reg)) + CAL_YEAR_W'(YEAR_BASE);
    assign y_prev = y_cur - CAL_YEAR_W'(1);

    // divide by 100 through the reciprocal, shared by both quotient steps
    assign div_n    = (cmd.op == OP_DIV_CUR) ? y_cur : y_prev;
    assign div_prod = DIV_PROD_W'(div_n) * DIV_PROD_W'(RECIP_100);
    assign div_q    = div_prod[RECIP_SHIFT +: CENTURY_W];

    // leap years from 1970 up to the previous year: n/4 - n/100 + n/400 - base
    assign leaps = CAL_YEAR_W'(y_prev[CAL_YEAR_W-1:2]) - CAL_YEAR_W'(q_prev_reg)
                 + CAL_YEAR_W'(q_prev_reg[CENTURY_W-1:2])
                 - CAL_YEAR_W'(LEAPS_BEFORE_EPOCH);
    assign has_years   = (year_reg > YEAR_W'(EPOCH_YEAR_OFF));
    assign whole_years = year_reg - YEAR_W'(EPOCH_YEAR_OFF);
    assign year_days   = has_years
                       ? (YEAR_DAYS_W'(whole_years) * YEAR_DAYS_W'(365) + YEAR_DAYS_W'(leaps))
                       : '0;

    // gregorian rule for the given year
    assign century_start = CAL_YEAR_W'(q_cur_reg) * CAL_YEAR_W'(100);
    assign leap_next = (y_cur[1:0] == 2'b00)
                     && ((y_cur != century_start) || (q_cur_reg[1:0] == 2'b00));

    // accumulator steps
    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.op)
            OP_YEAR:  acc_next = EPOCH_W'(year_days);
            OP_MONTH: acc_next = acc_reg + EPOCH_W'(month_start(leap_reg, month_reg))
                               + EPOCH_W'(mday_reg) - EPOCH_W'(1);
            OP_HOUR:  acc_next = EPOCH_W'(acc_reg * EPOCH_W'(24)) + EPOCH_W'(hour_reg);
            OP_MIN:   acc_next = EPOCH_W'(acc_reg * EPOCH_W'(60)) + EPOCH_W'(minute_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    // payload, quotient, leap, accumulator and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            year_reg   <= year_from_1900;
            month_reg  <= month;
            mday_reg   <= day_of_month;
            hour_reg   <= hour;
            minute_reg <= minute;
            second_reg <= second;
        end
        if (cmd.op == OP_DIV_PREV)
        begin
            q_prev_reg <= div_q;
        end
        if (cmd.op == OP_DIV_CUR)
        begin
            q_cur_reg <= div_q;
        end
        if (cmd.op == OP_YEAR)
        begin
            leap_reg <= leap_next;
        end
        acc_reg <= acc_next;
        if (cmd.op == OP_SEC && out_free)
        begin
            epoch_reg <= EPOCH_W'(acc_reg * EPOCH_W'(60)) + EPOCH_W'(second_reg);
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_SEC && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;

endmodule

// ----- design/calendar_to_epoch_seconds.sv -----
// top level: utc broken-down time to seconds since 1970-01-01
// requests are taken one at a time: a new request is accepted only in the load step, after the
// previous item has run the whole step sequence through one shared datapath
// (load, two century quotients, year days, month days, then three multiply-add steps)
// a result waiting in the output register holds the final step until it is taken
// reset: rst_n clears the sequencer and the response valid; no item is held after reset
module calendar_to_epoch_seconds
    import cts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    cts_req_if.sink   req,
    cts_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;
    logic dp_out_free;

    // request handshake
    assign req.ready      = (cmd.op == OP_LOAD);
    assign sts.accept     = req.valid && req.ready;
    assign sts.out_free   = dp_out_free;

    cts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    cts_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .accept         (sts.accept),
        .year_from_1900 (req.year_from_1900),
        .month          (req.month),
        .day_of_month   (req.day_of_month),
        .hour           (req.hour),
        .minute         (req.minute),
        .second         (req.second),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .epoch_seconds  (rsp.epoch_seconds),
        .out_free       (dp_out_free)
    );

    // an accepted item reaches the final step after the fixed sequence
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        sts.accept |=> ##6 (cmd.op == OP_SEC))
        else $error("final step not reached after accept");

    // the final step with a free output register presents a result
    a_sec_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SEC) && sts.out_free |=> rsp.valid)
        else $error("result not presented after final step");

    // a response appears only out of the final step
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.op == OP_SEC))
        else $error("response valid without final step");

endmodule
